[sv/magnetometer_minmax_calibration_defines.svh]
// Assertion macros used by the checker file.
// Each expands to a labeled concurrent assertion clocked on clk and
// disabled while arst_n is low.
`ifndef MAGNETOMETER_MINMAX_CALIBRATION_DEFINES_SVH
`define MAGNETOMETER_MINMAX_CALIBRATION_DEFINES_SVH

// Same-cycle implication.
`define MMCAL_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mmcal: property violated");

// Next-cycle implication.
`define MMCAL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mmcal: property violated");

`endif

[sv/mmcal_pkg.sv]
`timescale 1ns / 1ps

package mmcal_pkg;

	// Defaults for the top level parameters
	localparam int SAMPLE_BITS_DEF     = 16;
	localparam int SCALE_FRAC_BITS_DEF = 12;

	// Fixed field widths
	localparam int REG_W     = 16;
	localparam int AXES      = 3;
	localparam int CFG_IDX_W = 3;

	// Divider: one bit past the 16-bit scale flags an overflowing quotient
	localparam int DIV_SHIFT = REG_W;
	localparam int QUOT_BITS = REG_W + 1;
	localparam int CNT_W     = $clog2(QUOT_BITS);

	localparam logic [REG_W-1:0] SCALE_MAX   = 16'hFFFF;
	localparam logic [REG_W-1:0] SCALE_RESET = 16'd4096;

	// Operation codes
	typedef enum logic [1:0] {
		OP_CORRECT = 2'd0,
		OP_COLLECT = 2'd1,
		OP_START   = 2'd2,
		OP_STOP    = 2'd3
	} op_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_EN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Z    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z   = 3'd6;

	// Strobes from the sequencer to the axis lanes and the merge stage
	typedef struct packed {
		logic accept;   // input word taken
		logic start;    // clear extremes
		logic collect;  // fold sample into extremes
		logic sum;      // latch spread, bias and total
		logic load;     // load the divider
		logic step;     // one quotient bit
		logic fin;      // write computed scale
	} lane_ctrl_t;

endpackage

[sv/mmcal_lane.sv]
`timescale 1ns / 1ps

module mmcal_lane #(
	parameter int SAMPLE_BITS     = mmcal_pkg::SAMPLE_BITS_DEF,
	parameter int SCALE_FRAC_BITS = mmcal_pkg::SCALE_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mmcal_pkg::lane_ctrl_t                 ctrl,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	input  logic                                  manual_enable,
	input  logic signed [mmcal_pkg::REG_W-1:0]    manual_bias,
	input  logic        [mmcal_pkg::REG_W-1:0]    manual_scale,
	input  logic signed [SAMPLE_BITS+2:0]         total,
	output logic signed [SAMPLE_BITS:0]           spread,
	output logic signed [SAMPLE_BITS-1:0]         corrected,
	output logic        [mmcal_pkg::REG_W-1:0]    bias_out,
	output logic        [mmcal_pkg::REG_W-1:0]    scale_out
);
	import mmcal_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int F    = SCALE_FRAC_BITS;
	localparam int BW   = (SB > REG_W) ? SB : REG_W;
	localparam int SCW  = REG_W + 1;
	localparam int NUMW = SB + 3 + F;
	localparam int CW   = (NUMW > SB + 2 + DIV_SHIFT) ? NUMW : SB + 2 + DIV_SHIFT;
	localparam int PW   = BW + SCW + 2;

	localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
	localparam logic signed [PW-1:0] PMAX = PW'(SMAX);
	localparam logic signed [PW-1:0] PMIN = PW'(SMIN);

	logic signed [SB-1:0]      max_q, min_q, cbias_q;
	logic        [SCW-1:0]     cscale_q;
	logic signed [SB:0]        d_q;
	logic        [SB:0]        bsum;
	logic        [CW-1:0]      rem_q, dsh_q;
	logic        [QUOT_BITS-1:0] quo_q;
	logic                      sat_q, zero_q, ge;
	logic        [SB-1:0]      du;
	logic        [SB+1:0]      three;
	logic        [NUMW-1:0]    num;
	logic signed [BW-1:0]      bias_eff;
	logic        [SCW-1:0]     scale_eff;
	logic signed [BW:0]        diff_s1;
	logic signed [PW-1:0]      prod, rnd, shf;

	// Spread and midpoint of the tracked extremes
	assign spread = {max_q[SB-1], max_q} - {min_q[SB-1], min_q};
	assign bsum   = {max_q[SB-1], max_q} + {min_q[SB-1], min_q};

	// Track per-axis extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= SMIN;
			min_q <= SMAX;
		end else if (ctrl.start) begin
			max_q <= SMIN;
			min_q <= SMAX;
		end else if (ctrl.collect) begin
			if (sample > max_q)
				max_q <= sample;
			if (sample < min_q)
				min_q <= sample;
		end
	end

	// Divider operands: num = total*2^F + floor(3d/2), den = 3d
	assign du    = d_q[SB-1:0];
	assign three = (SB+2)'(du) + ((SB+2)'(du) << 1);
	assign num   = (NUMW'($unsigned(total)) << F) + NUMW'(three >> 1);
	assign ge    = (rem_q >= dsh_q);

	// Restoring divider, one quotient bit per step, top bit first
	always_ff @(posedge clk) begin
		if (ctrl.sum)
			d_q <= spread;
		if (ctrl.load) begin
			rem_q  <= CW'(num);
			dsh_q  <= CW'(three) << DIV_SHIFT;
			quo_q  <= '0;
			sat_q  <= (d_q <= 0);
			zero_q <= (total <= 0);
		end else if (ctrl.step) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QUOT_BITS-2:0], ge};
		end
	end

	// Computed bias and scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cbias_q  <= '0;
			cscale_q <= SCW'(1) << F;
		end else begin
			if (ctrl.sum)
				cbias_q <= bsum[SB:1];
			if (ctrl.fin) begin
				if (sat_q)
					cscale_q <= SCW'(SCALE_MAX);
				else if (zero_q)
					cscale_q <= '0;
				else if (quo_q[QUOT_BITS-1])
					cscale_q <= SCW'(SCALE_MAX);
				else
					cscale_q <= SCW'(quo_q[REG_W-1:0]);
			end
		end
	end

	// Pick manual or computed values
	assign bias_eff  = manual_enable ? BW'(manual_bias) : BW'(cbias_q);
	assign scale_eff = manual_enable ? SCW'(manual_scale) : cscale_q;
	assign bias_out  = bias_eff[REG_W-1:0];
	assign scale_out = scale_eff[REG_W-1:0];

	// Remove bias as the word is taken
	always_ff @(posedge clk) begin
		if (ctrl.accept)
			diff_s1 <= (BW+1)'(sample) - (BW+1)'(bias_eff);
	end

	// Scale, round half up, saturate
	always_comb begin
		prod = diff_s1 * $signed({1'b0, scale_eff});
		rnd  = prod + (PW'(1) << (F - 1));
		shf  = rnd >>> F;
		if (shf > PMAX)
			corrected = SMAX;
		else if (shf < PMIN)
			corrected = SMIN;
		else
			corrected = shf[SB-1:0];
	end

endmodule

[sv/mmcal_merge.sv]
`timescale 1ns / 1ps

module mmcal_merge #(
	parameter int SAMPLE_BITS = mmcal_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  mmcal_pkg::lane_ctrl_t         ctrl,
	input  logic signed [SAMPLE_BITS:0]   spread [mmcal_pkg::AXES],
	output logic signed [SAMPLE_BITS+2:0] total
);
	import mmcal_pkg::*;

	localparam int TW = SAMPLE_BITS + 3;

	logic signed [TW-1:0] total_q, sum_c;

	// Add the lane spreads
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < AXES; i++)
			sum_c = sum_c + TW'(spread[i]);
	end

	// Hold the total for the divide
	always_ff @(posedge clk) begin
		if (ctrl.sum)
			total_q <= sum_c;
	end

	assign total = total_q;

endmodule

[sv/magnetometer_minmax_calibration.sv]
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_ready  | operation, sample_x/y/z
// out      | out_valid/out_ready  | corrected_x/y/z, calibrating, bias_out_x/y/z,
//          |                      | scale_out_x/y/z
// cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data (cfg_ready always high)
//
// Correct, collect, start and an idle stop: one word per cycle unless the output stalls;
// each word passes the bias subtract stage, then the multiply into the output register.
// A stop during a run drops in_ready for the spread/total latch, divider
// load, 17 steps of the per-lane restoring divider and scale write.
// Reset clears extremes, computed and manual values; no clearing pass.
// A stalled output holds one finished word while one more waits in the bias stage.

module magnetometer_minmax_calibration #(
	parameter int SAMPLE_BITS     = mmcal_pkg::SAMPLE_BITS_DEF,
	parameter int SCALE_FRAC_BITS = mmcal_pkg::SCALE_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            operation,
	input  logic signed [SAMPLE_BITS-1:0]         sample_x,
	input  logic signed [SAMPLE_BITS-1:0]         sample_y,
	input  logic signed [SAMPLE_BITS-1:0]         sample_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [SAMPLE_BITS-1:0]         corrected_x,
	output logic signed [SAMPLE_BITS-1:0]         corrected_y,
	output logic signed [SAMPLE_BITS-1:0]         corrected_z,
	output logic                                  calibrating,
	output logic signed [mmcal_pkg::REG_W-1:0]    bias_out_x,
	output logic signed [mmcal_pkg::REG_W-1:0]    bias_out_y,
	output logic signed [mmcal_pkg::REG_W-1:0]    bias_out_z,
	output logic        [mmcal_pkg::REG_W-1:0]    scale_out_x,
	output logic        [mmcal_pkg::REG_W-1:0]    scale_out_y,
	output logic        [mmcal_pkg::REG_W-1:0]    scale_out_z,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mmcal_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mmcal_pkg::REG_W-1:0]           cfg_data
);
	import mmcal_pkg::*;

	localparam int SB = SAMPLE_BITS;

	typedef enum logic [4:0] {
		ST_RUN  = 5'b00001,
		ST_SUM  = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        cnt_q;
	logic                    prog_q;
	logic                    s1_valid_q;
	op_t                     op_s1, op_in;
	logic                    out_valid_q, calib_q;
	logic signed [SB-1:0]    corr_q [AXES];
	logic [REG_W-1:0]        bias_q [AXES];
	logic [REG_W-1:0]        scale_q [AXES];
	logic                    man_en_q;
	logic [REG_W-1:0]        man_bias_q [AXES];
	logic [REG_W-1:0]        man_scale_q [AXES];
	logic                    in_acc, out_free, s1_adv, run_calc;
	lane_ctrl_t              ctrl;
	logic signed [SB-1:0]    smp [AXES];
	logic signed [SB:0]      spread [AXES];
	logic signed [SB+2:0]    total;
	logic signed [SB-1:0]    corr [AXES];
	logic [REG_W-1:0]        bias_eff [AXES];
	logic [REG_W-1:0]        scale_eff [AXES];

	// Handshake
	assign op_in     = op_t'(operation);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign s1_adv    = s1_valid_q && (state_q == ST_RUN) && out_free;
	assign in_ready  = (state_q == ST_RUN) && (!s1_valid_q || out_free);
	assign run_calc  = in_acc && (op_in == OP_STOP) && prog_q;
	assign cfg_ready = 1'b1;

	// Lane strobes
	always_comb begin
		ctrl.accept  = in_acc;
		ctrl.start   = in_acc && (op_in == OP_START);
		ctrl.collect = in_acc && (op_in == OP_COLLECT);
		ctrl.sum     = (state_q == ST_SUM);
		ctrl.load    = (state_q == ST_LOAD);
		ctrl.step    = (state_q == ST_DIV);
		ctrl.fin     = (state_q == ST_FIN);
	end

	// Calibration sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN:  if (run_calc) state_d = ST_SUM;
			ST_SUM:  state_d = ST_LOAD;
			ST_LOAD: state_d = ST_DIV;
			ST_DIV:  if (cnt_q == '0) state_d = ST_FIN;
			ST_FIN:  state_d = ST_RUN;
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD)
				cnt_q <= CNT_W'(QUOT_BITS - 1);
			else if (state_q == ST_DIV)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Run flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prog_q <= 1'b0;
		else if (in_acc) begin
			if (op_in == OP_START)
				prog_q <= 1'b1;
			else if (op_in == OP_STOP)
				prog_q <= 1'b0;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			man_en_q <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				man_bias_q[i]  <= '0;
				man_scale_q[i] <= SCALE_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MANUAL_EN: man_en_q       <= cfg_data[0];
				CFG_BIAS_X:    man_bias_q[0]  <= cfg_data;
				CFG_BIAS_Y:    man_bias_q[1]  <= cfg_data;
				CFG_BIAS_Z:    man_bias_q[2]  <= cfg_data;
				CFG_SCALE_X:   man_scale_q[0] <= cfg_data;
				CFG_SCALE_Y:   man_scale_q[1] <= cfg_data;
				CFG_SCALE_Z:   man_scale_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Axis lanes
	assign smp[0] = sample_x;
	assign smp[1] = sample_y;
	assign smp[2] = sample_z;

	for (genvar i = 0; i < AXES; i++) begin : g_lane
		mmcal_lane #(
			.SAMPLE_BITS     (SAMPLE_BITS),
			.SCALE_FRAC_BITS (SCALE_FRAC_BITS)
		) u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.sample        (smp[i]),
			.manual_enable (man_en_q),
			.manual_bias   (man_bias_q[i]),
			.manual_scale  (man_scale_q[i]),
			.total         (total),
			.spread        (spread[i]),
			.corrected     (corr[i]),
			.bias_out      (bias_eff[i]),
			.scale_out     (scale_eff[i])
		);
	end

	mmcal_merge #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_merge (
		.clk    (clk),
		.ctrl   (ctrl),
		.spread (spread),
		.total  (total)
	);

	// Bias stage: hold the operation until the word moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_acc)
			s1_valid_q <= 1'b1;
		else if (s1_adv)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			op_s1 <= op_in;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= 1'b1;
		else if (out_valid_q && out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			calib_q <= prog_q;
			for (int i = 0; i < AXES; i++) begin
				corr_q[i]  <= (op_s1 == OP_CORRECT) ? corr[i] : '0;
				bias_q[i]  <= bias_eff[i];
				scale_q[i] <= scale_eff[i];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign calibrating = calib_q;
	assign corrected_x = corr_q[0];
	assign corrected_y = corr_q[1];
	assign corrected_z = corr_q[2];
	assign bias_out_x  = bias_q[0];
	assign bias_out_y  = bias_q[1];
	assign bias_out_z  = bias_q[2];
	assign scale_out_x = scale_q[0];
	assign scale_out_y = scale_q[1];
	assign scale_out_z = scale_q[2];

endmodule

[sv/mmcal_checker.sv]
`timescale 1ns / 1ps
`include "magnetometer_minmax_calibration_defines.svh"

module mmcal_checker #(
	parameter int SAMPLE_BITS = mmcal_pkg::SAMPLE_BITS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic [1:0]                         operation,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [SAMPLE_BITS-1:0]             corrected_x,
	input logic                               calibrating,
	input logic [mmcal_pkg::REG_W-1:0]        bias_out_x,
	input logic [mmcal_pkg::REG_W-1:0]        scale_out_x
);
	import mmcal_pkg::*;

	logic       run_q;
	logic [1:0] pend_q;
	logic       in_acc, out_acc;
	logic [SAMPLE_BITS+2*REG_W:0] out_word;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Watched output fields as one vector
	assign out_word = {corrected_x, calibrating, bias_out_x, scale_out_x};

	// Follow the run flag and the words in flight from the ports
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			pend_q <= '0;
		end else begin
			if (in_acc && operation == OP_START)
				run_q <= 1'b1;
			else if (in_acc && operation == OP_STOP)
				run_q <= 1'b0;
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	`MMCAL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
	`MMCAL_ASSERT_NEXT(a_stop_busy, in_acc && operation == OP_STOP && run_q, !in_ready)
	`MMCAL_ASSERT_IMPL(a_no_extra, out_valid, pend_q != 2'd0)
	`MMCAL_ASSERT_IMPL(a_depth, in_acc, pend_q != 2'd2 || out_ready)

endmodule

bind magnetometer_minmax_calibration mmcal_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_mmcal_checker (.*);
